>>> rtl/core/wbrb_pkg.sv
`default_nettype none

package wbrb_pkg;

    // Width of counts, capacities and internal positions.
    localparam int CNT_W = 11;
    // Width of the reported positions.
    localparam int POS_OUT_W = 10;
    localparam int DATA_W = 8;
    localparam int FUNC_W = 3;

    // Default number of byte entries in the store.
    localparam int STORE_DEPTH_DEF = 1024;
    // Capacity register value after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    // Register index, taken from the word address bit.
    localparam logic REG_CAPACITY = 1'b0;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_WR_BYTE   = 3'd0,
        FN_RD_BYTE   = 3'd1,
        FN_WR_SPAN   = 3'd2,
        FN_RD_SPAN   = 3'd3,
        FN_WR_ADV    = 3'd4,
        FN_RD_ADV    = 3'd5,
        FN_CLEAR     = 3'd6,
        FN_STATUS    = 3'd7
    } func_t;

    // Status of the buffer after one operation.
    typedef struct packed {
        logic [CNT_W-1:0] granted;
        logic [CNT_W-1:0] read_rem;
        logic [CNT_W-1:0] write_rem;
        logic [CNT_W-1:0] read_contig;
        logic [CNT_W-1:0] write_contig;
        logic [CNT_W-1:0] head;
        logic [CNT_W-1:0] tail;
        logic             wrap;
        logic             rd_hit;
    } result_t;

    // Store access requested by one operation.
    typedef struct packed {
        logic             we;
        logic [CNT_W-1:0] waddr;
        logic             re;
        logic [CNT_W-1:0] raddr;
    } mem_req_t;

    // Difference clipped at zero.
    function automatic logic [CNT_W-1:0] sub0(input logic [CNT_W-1:0] a,
                                              input logic [CNT_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/wrapping_byte_ring_buffer_unit.sv
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+---------------------------------------------------
// in      | in  | in_valid, in_stall   | func, data_in, amount
// out     | out | out_valid, out_stall | granted, data_out, space counts, positions, wrapping
// cfg     | in  | APB psel, penable    | paddr, pwdata, prdata (capacity at 0x0)
//
// One item per cycle sustained while out_stall is low. A result reaches the output in order:
// the input register holds the item, and the result register and the store's
// registered read load together when the item advances.
// Reset clears the positions and wrap flag and sets the capacity to 1024; the
// byte store is not cleared and needs no clearing pass.
// The result register holds while out_stall is high, and in_stall rises only
// when the input register is full and the result register cannot drain.
`default_nettype none

module wrapping_byte_ring_buffer_unit
    import wbrb_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Item channel
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [DATA_W-1:0]  data_in,
    input  wire logic [CNT_W-1:0]   amount,
    // Result channel
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic [CNT_W-1:0]   granted,
    output      logic [DATA_W-1:0]  data_out,
    output      logic [CNT_W-1:0]   read_remaining,
    output      logic [CNT_W-1:0]   write_remaining,
    output      logic [CNT_W-1:0]   read_contiguous,
    output      logic [CNT_W-1:0]   write_contiguous,
    output      logic [POS_OUT_W-1:0] read_position,
    output      logic [POS_OUT_W-1:0] write_position,
    output      logic               wrapping,
    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready
);

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CAP_MAX = (STORE_DEPTH > CNT_MAX) ? CNT_MAX : STORE_DEPTH;
    localparam logic [CNT_W-1:0] CAP_MAX_C = CNT_W'(CAP_MAX);
    localparam logic [CNT_W-1:0] CAP_EFF_RESET = (CAP_RESET > CAP_MAX_C) ? CAP_MAX_C
                                                                          : CAP_RESET;

    // Configuration registers: the written value and the capacity in effect.
    logic [CNT_W-1:0] cap_raw_reg, cap_raw_next;
    logic [CNT_W-1:0] cap_eff_reg, cap_eff_next;
    logic             cfg_wr, cfg_clear;
    logic [CNT_W-1:0] wr_val;

    // Pipeline registers.
    logic             s1_valid_reg, s1_valid_next;
    func_t            s1_func_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic [CNT_W-1:0] s1_amount_reg;
    logic             s2_valid_reg, s2_valid_next;
    result_t          s2_res_reg;

    logic             s2_ready, advance, in_accept;
    result_t          op_res;
    mem_req_t         mem;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Register write and read-back.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_clear = cfg_wr && (paddr[2] == REG_CAPACITY);
    assign wr_val = pwdata[CNT_W-1:0];
    assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_raw_reg) : '0;

    always_comb
    begin
        cap_raw_next = cap_raw_reg;
        cap_eff_next = cap_eff_reg;
        if (cfg_clear)
        begin
            cap_raw_next = wr_val;
            if (wr_val == '0)
            begin
                cap_eff_next = CNT_W'(1);
            end
            else if (wr_val > CAP_MAX_C)
            begin
                cap_eff_next = CAP_MAX_C;
            end
            else
            begin
                cap_eff_next = wr_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_raw_reg <= CAP_RESET;
            cap_eff_reg <= CAP_EFF_RESET;
        end
        else
        begin
            cap_raw_reg <= cap_raw_next;
            cap_eff_reg <= cap_eff_next;
        end
    end

    // Handshake: the result register drains or is empty, so the input register moves.
    assign s2_ready  = !s2_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && s2_ready;
    assign in_stall  = s1_valid_reg && !s2_ready;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (advance)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_valid_reg && !out_stall)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg   <= func_t'(func);
            s1_data_reg   <= data_in;
            s1_amount_reg <= amount;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_res_reg <= op_res;
        end
    end

    // Position and space logic.
    wbrb_ptr u_ptr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_eff_reg),
        .cfg_clear (cfg_clear),
        .fire      (advance),
        .func      (s1_func_reg),
        .amount    (s1_amount_reg),
        .res       (op_res),
        .mem       (mem)
    );

    // Store addresses at the depth of the memory.
    if (ADDR_W <= CNT_W)
    begin : g_addr_narrow
        assign ram_waddr = mem.waddr[ADDR_W-1:0];
        assign ram_raddr = mem.raddr[ADDR_W-1:0];
    end
    else
    begin : g_addr_wide
        assign ram_waddr = {{(ADDR_W-CNT_W){1'b0}}, mem.waddr};
        assign ram_raddr = {{(ADDR_W-CNT_W){1'b0}}, mem.raddr};
    end

    // Byte store.
    wbrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem.we),
        .waddr (ram_waddr),
        .wdata (s1_data_reg),
        .re    (mem.re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result outputs.
    assign out_valid        = s2_valid_reg;
    assign granted          = s2_res_reg.granted;
    assign data_out         = s2_res_reg.rd_hit ? ram_rdata : '0;
    assign read_remaining   = s2_res_reg.read_rem;
    assign write_remaining  = s2_res_reg.write_rem;
    assign read_contiguous  = s2_res_reg.read_contig;
    assign write_contiguous = s2_res_reg.write_contig;
    assign read_position    = s2_res_reg.head[POS_OUT_W-1:0];
    assign write_position   = s2_res_reg.tail[POS_OUT_W-1:0];
    assign wrapping         = s2_res_reg.wrap;

`ifndef ASSERT_OFF
    // The input register only stalls when a full result register is held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s2_valid_reg && out_stall))
        else $error("input stalled without a held result");

    // A byte read moves to the result register together with its store read.
    a_read_paired: assert property (@(posedge clk) disable iff (!rst_n)
        mem.re |=> (s2_valid_reg && s2_res_reg.rd_hit))
        else $error("store read without a matching result");

    // The capacity in effect never leaves its legal range.
    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_eff_reg != '0) && (cap_eff_reg <= CAP_MAX_C))
        else $error("capacity out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/core/wbrb_ram.sv
`default_nettype none

module wbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/wbrb_ptr.sv
`default_nettype none

module wbrb_ptr
    import wbrb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] cap,
    input  wire logic             cfg_clear,
    input  wire logic             fire,
    input  wire func_t            func,
    input  wire logic [CNT_W-1:0] amount,
    output      result_t          res,
    output      mem_req_t         mem
);

    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] tail_reg, tail_next;
    logic             wrap_reg, wrap_next;

    logic [CNT_W-1:0] wc_cur, rc_cur, grant;
    logic [CNT_W:0]   tail_sum, head_sum;
    logic             tail_over, head_over;
    logic [CNT_W-1:0] tail_adv, head_adv;
    logic [CNT_W-1:0] head_op, tail_op;
    logic             wrap_op;
    logic             is_wr, is_rd;

    // Contiguous space before the operation.
    always_comb
    begin
        wc_cur = wrap_reg ? sub0(head_reg, tail_reg) : sub0(cap, tail_reg);
        rc_cur = wrap_reg ? sub0(cap, head_reg) : sub0(tail_reg, head_reg);
    end

    // Bytes granted by the operation.
    always_comb
    begin
        grant = '0;
        is_wr = 1'b0;
        is_rd = 1'b0;
        case (func)
            FN_WR_BYTE:
            begin
                grant = (wc_cur != '0) ? CNT_W'(1) : '0;
                is_wr = 1'b1;
            end
            FN_RD_BYTE:
            begin
                grant = (rc_cur != '0) ? CNT_W'(1) : '0;
                is_rd = 1'b1;
            end
            FN_WR_SPAN:
            begin
                grant = (amount < wc_cur) ? amount : wc_cur;
                is_wr = 1'b1;
            end
            FN_RD_SPAN:
            begin
                grant = (amount < rc_cur) ? amount : rc_cur;
                is_rd = 1'b1;
            end
            FN_WR_ADV:
            begin
                grant = (amount < cap) ? amount : cap;
                is_wr = 1'b1;
            end
            FN_RD_ADV:
            begin
                grant = (amount < cap) ? amount : cap;
                is_rd = 1'b1;
            end
            default:
            begin
                grant = '0;
            end
        endcase
    end

    // Position advance with a single wrap at the capacity.
    always_comb
    begin
        tail_sum  = {1'b0, tail_reg} + {1'b0, grant};
        head_sum  = {1'b0, head_reg} + {1'b0, grant};
        tail_over = (tail_sum >= {1'b0, cap});
        head_over = (head_sum >= {1'b0, cap});
        tail_adv  = tail_over ? CNT_W'(tail_sum - {1'b0, cap}) : tail_sum[CNT_W-1:0];
        head_adv  = head_over ? CNT_W'(head_sum - {1'b0, cap}) : head_sum[CNT_W-1:0];
    end

    // State after the operation.
    always_comb
    begin
        head_op = head_reg;
        tail_op = tail_reg;
        wrap_op = wrap_reg;
        if (func == FN_CLEAR)
        begin
            head_op = '0;
            tail_op = '0;
            wrap_op = 1'b0;
        end
        else if (is_wr)
        begin
            tail_op = tail_adv;
            wrap_op = tail_over ? 1'b1 : wrap_reg;
        end
        else if (is_rd)
        begin
            head_op = head_adv;
            wrap_op = head_over ? 1'b0 : wrap_reg;
        end
    end

    // Status reported for the new state.
    always_comb
    begin
        res.granted = grant;
        res.head    = head_op;
        res.tail    = tail_op;
        res.wrap    = wrap_op;
        res.rd_hit  = (func == FN_RD_BYTE) && (grant != '0);
        if (wrap_op)
        begin
            res.write_rem    = sub0(head_op, tail_op);
            res.read_rem     = cap - res.write_rem;
            res.write_contig = res.write_rem;
            res.read_contig  = sub0(cap, head_op);
        end
        else
        begin
            res.read_rem     = sub0(tail_op, head_op);
            res.write_rem    = cap - res.read_rem;
            res.read_contig  = res.read_rem;
            res.write_contig = sub0(cap, tail_op);
        end
    end

    // Byte store access, only when the operation moves to the result stage.
    always_comb
    begin
        mem.we    = fire && (func == FN_WR_BYTE) && (grant != '0);
        mem.waddr = tail_reg;
        mem.re    = fire && res.rd_hit;
        mem.raddr = head_reg;
    end

    // A capacity write clears the positions; otherwise each transfer updates them.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        wrap_next = wrap_reg;
        if (cfg_clear)
        begin
            head_next = '0;
            tail_next = '0;
            wrap_next = 1'b0;
        end
        else if (fire)
        begin
            head_next = head_op;
            tail_next = tail_op;
            wrap_next = wrap_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            wrap_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            wrap_reg <= wrap_next;
        end
    end

`ifndef ASSERT_OFF
    // Both positions always stay inside the used part of the store.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg < cap) && (tail_reg < cap))
        else $error("position outside capacity");

    // One operation never both writes and reads the store.
    a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem.we && mem.re))
        else $error("store read and write in one operation");

    // No operation grants more than the capacity.
    a_grant_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (res.granted <= cap))
        else $error("grant exceeds capacity");

    // Held and free bytes always add up to the capacity.
    a_rem_sum: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (({1'b0, res.read_rem} + {1'b0, res.write_rem}) == {1'b0, cap}))
        else $error("remaining counts do not sum to capacity");
`endif

endmodule

`default_nettype wire

>>> dv/wrapping_byte_ring_buffer_unit_tb.sv
`timescale 1ns / 100ps

module wrapping_byte_ring_buffer_unit_tb;
    import wbrb_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int NUM_PHASES = 11;
    localparam int PHASE_ITEMS = 118;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
    // Word address of a register index that does not exist.
    localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};

    // One result as seen on the output ports.
    typedef struct packed {
        logic [CNT_W-1:0]     granted;
        logic [DATA_W-1:0]    data;
        logic [CNT_W-1:0]     rd_rem;
        logic [CNT_W-1:0]     wr_rem;
        logic [CNT_W-1:0]     rd_contig;
        logic [CNT_W-1:0]     wr_contig;
        logic [POS_OUT_W-1:0] rd_pos;
        logic [POS_OUT_W-1:0] wr_pos;
        logic                 wrap;
    } ring_res_t;

    // One row of the directed sequence: a register write or an operation.
    typedef struct packed {
        logic               cfg;
        logic [PADDR_W-1:0] addr;
        logic [PDATA_W-1:0] wdata;
        func_t              f;
        logic [DATA_W-1:0]  din;
        logic [CNT_W-1:0]   amt;
        logic               typed;
        ring_res_t          res;
    } plan_row_t;

    localparam ring_res_t EMPTY_1K =
        '{11'd0, 8'd0, 11'd0, 11'd1024, 11'd0, 11'd1024, 10'd0, 10'd0, 1'b0};

    localparam int NUM_PLAN = 25;
    localparam plan_row_t PLAN [NUM_PLAN] = '{
        // Empty buffer right after reset.
        '{1'b0, CAP_ADDR, 32'd0, FN_STATUS, 8'h00, 11'd0, 1'b1, EMPTY_1K},
        '{1'b0, CAP_ADDR, 32'd0, FN_RD_BYTE, 8'h00, 11'd0, 1'b1, EMPTY_1K},
        '{1'b0, CAP_ADDR, 32'd0, FN_RD_SPAN, 8'h00, 11'd5, 1'b1, EMPTY_1K},
        // Byte transfers with extreme data.
        '{1'b0, CAP_ADDR, 32'd0, FN_WR_BYTE, 8'hFF, 11'd0, 1'b1,
          '{11'd1, 8'h00, 11'd1, 11'd1023, 11'd1, 11'd1023, 10'd0, 10'd1, 1'b0}},
        '{1'b0, CAP_ADDR, 32'd0, FN_WR_BYTE, 8'h00, 11'd0, 1'b0, '0},
        '{1'b0, CAP_ADDR, 32'd0, FN_RD_BYTE, 8'h00, 11'd0, 1'b1,
          '{11'd1, 8'hFF, 11'd1, 11'd1023, 11'd1, 11'd1022, 10'd1, 10'd2, 1'b0}},
        '{1'b0, CAP_ADDR, 32'd0, FN_RD_BYTE, 8'h00, 11'd0, 1'b0, '0},
        // Largest amounts on spans and unclamped advances.
        '{1'b0, CAP_ADDR, 32'd0, FN_WR_SPAN, 8'h00, 11'd2047, 1'b0, '0},
        '{1'b0, CAP_ADDR, 32'd0, FN_RD_ADV, 8'h00, 11'd2047, 1'b0, '0},
        '{1'b0, CAP_ADDR, 32'd0, FN_CLEAR, 8'h00, 11'd0, 1'b1, EMPTY_1K},
        '{1'b0, CAP_ADDR, 32'd0, FN_WR_ADV, 8'h00, 11'd1024, 1'b1,
          '{11'd1024, 8'd0, 11'd1024, 11'd0, 11'd1024, 11'd0, 10'd0, 10'd0, 1'b1}},
        // Write into a full buffer is refused.
        '{1'b0, CAP_ADDR, 32'd0, FN_WR_BYTE, 8'h5A, 11'd0, 1'b1,
          '{11'd0, 8'd0, 11'd1024, 11'd0, 11'd1024, 11'd0, 10'd0, 10'd0, 1'b1}},
        // Write position overruns the read position.
        '{1'b0, CAP_ADDR, 32'd0, FN_WR_ADV, 8'h00, 11'd3, 1'b0, '0},
        '{1'b0, CAP_ADDR, 32'd0, FN_RD_SPAN, 8'h00, 11'd2047, 1'b0, '0},
        '{1'b0, CAP_ADDR, 32'd0, FN_STATUS, 8'h00, 11'd0, 1'b0, '0},
        // A capacity of zero acts as one byte.
        '{1'b1, CAP_ADDR, 32'd0, FN_STATUS, 8'h00, 11'd0, 1'b0, '0},
        '{1'b0, CAP_ADDR, 32'd0, FN_STATUS, 8'h00, 11'd0, 1'b1,
          '{11'd0, 8'd0, 11'd0, 11'd1, 11'd0, 11'd1, 10'd0, 10'd0, 1'b0}},
        '{1'b0, CAP_ADDR, 32'd0, FN_WR_BYTE, 8'hA5, 11'd0, 1'b0, '0},
        '{1'b0, CAP_ADDR, 32'd0, FN_WR_BYTE, 8'h3C, 11'd0, 1'b0, '0},
        '{1'b0, CAP_ADDR, 32'd0, FN_RD_BYTE, 8'h00, 11'd0, 1'b0, '0},
        // Capacity above the store depth, upper data bits set.
        '{1'b1, CAP_ADDR, 32'hFFFF_FFFF, FN_STATUS, 8'h00, 11'd0, 1'b0, '0},
        '{1'b0, CAP_ADDR, 32'd0, FN_WR_ADV, 8'h00, 11'd0, 1'b0, '0},
        // Read position overruns the write position.
        '{1'b0, CAP_ADDR, 32'd0, FN_RD_ADV, 8'h00, 11'd1, 1'b0, '0},
        // A write to an unmapped index leaves the positions alone.
        '{1'b1, SPARE_ADDR, 32'd5, FN_STATUS, 8'h00, 11'd0, 1'b0, '0},
        '{1'b0, CAP_ADDR, 32'd0, FN_STATUS, 8'h00, 11'd0, 1'b0, '0}
    };

    // Clock, reset and block ports.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [FUNC_W-1:0] func = '0;
    logic [DATA_W-1:0] data_in = '0;
    logic [CNT_W-1:0] amount = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CNT_W-1:0] granted;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0] read_remaining;
    logic [CNT_W-1:0] write_remaining;
    logic [CNT_W-1:0] read_contiguous;
    logic [CNT_W-1:0] write_contiguous;
    logic [POS_OUT_W-1:0] read_position;
    logic [POS_OUT_W-1:0] write_position;
    logic wrapping;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    // Shadow copy of the buffer state.
    logic [CNT_W-1:0] cap_reg = CAP_RESET;
    int head_pos = 0;
    int tail_pos = 0;
    bit wrap_st = 1'b0;
    logic [DATA_W-1:0] byte_mem [STORE_DEPTH_DEF];
    bit byte_seen [STORE_DEPTH_DEF];

    ring_res_t pending_status [$];
    int fail_count = 0;
    int cycle_count = 0;
    bit calm = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    wrapping_byte_ring_buffer_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .data_in          (data_in),
        .amount           (amount),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .granted          (granted),
        .data_out         (data_out),
        .read_remaining   (read_remaining),
        .write_remaining  (write_remaining),
        .read_contiguous  (read_contiguous),
        .write_contiguous (write_contiguous),
        .read_position    (read_position),
        .write_position   (write_position),
        .wrapping         (wrapping),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clip_sub(int a, int b);
        return (a > b) ? a - b : 0;
    endfunction

    // Zero maps to one byte, anything past the store depth to the depth.
    function automatic int eff_capacity();
        if (cap_reg == '0)
            return 1;
        if (int'(cap_reg) > STORE_DEPTH_DEF)
            return STORE_DEPTH_DEF;
        return int'(cap_reg);
    endfunction

    function automatic int wr_span_avail(int c);
        return wrap_st ? clip_sub(head_pos, tail_pos) : clip_sub(c, tail_pos);
    endfunction

    function automatic int rd_span_avail(int c);
        return wrap_st ? clip_sub(c, head_pos) : clip_sub(tail_pos, head_pos);
    endfunction

    // Passing the end subtracts the capacity once and sets the wrap flag.
    function automatic void move_tail(int n, int c);
        tail_pos += n;
        if (tail_pos >= c)
        begin
            wrap_st = 1'b1;
            tail_pos -= c;
        end
    endfunction

    function automatic void move_head(int n, int c);
        head_pos += n;
        if (head_pos >= c)
        begin
            wrap_st = 1'b0;
            head_pos -= c;
        end
    endfunction

    function automatic void clear_ring();
        head_pos = 0;
        tail_pos = 0;
        wrap_st = 1'b0;
    endfunction

    // Apply one operation to the shadow state and return the status it yields.
    function automatic ring_res_t ring_apply(func_t f, logic [DATA_W-1:0] din,
                                             logic [CNT_W-1:0] amt);
        ring_res_t r;
        int c;
        int g;
        int n;
        int rr;
        int wr;
        r = '0;
        c = eff_capacity();
        g = 0;
        case (f)
            FN_WR_BYTE:
                if (wr_span_avail(c) >= 1)
                begin
                    byte_mem[tail_pos] = din;
                    byte_seen[tail_pos] = 1'b1;
                    move_tail(1, c);
                    g = 1;
                end
            FN_RD_BYTE:
                if (rd_span_avail(c) >= 1)
                begin
                    r.data = byte_mem[head_pos];
                    move_head(1, c);
                    g = 1;
                end
            FN_WR_SPAN:
            begin
                n = wr_span_avail(c);
                g = (int'(amt) < n) ? int'(amt) : n;
                move_tail(g, c);
            end
            FN_RD_SPAN:
            begin
                n = rd_span_avail(c);
                g = (int'(amt) < n) ? int'(amt) : n;
                move_head(g, c);
            end
            FN_WR_ADV:
            begin
                g = (int'(amt) < c) ? int'(amt) : c;
                move_tail(g, c);
            end
            FN_RD_ADV:
            begin
                g = (int'(amt) < c) ? int'(amt) : c;
                move_head(g, c);
            end
            FN_CLEAR:
                clear_ring();
            default:
                ;
        endcase

        // Negative differences after an overrun count as zero.
        if (wrap_st)
        begin
            wr = clip_sub(head_pos, tail_pos);
            rr = c - wr;
        end
        else
        begin
            rr = clip_sub(tail_pos, head_pos);
            wr = c - rr;
        end
        r.granted = CNT_W'(g);
        r.rd_rem = CNT_W'(rr);
        r.wr_rem = CNT_W'(wr);
        r.rd_contig = CNT_W'(rd_span_avail(c));
        r.wr_contig = CNT_W'(wr_span_avail(c));
        r.rd_pos = POS_OUT_W'(head_pos);
        r.wr_pos = POS_OUT_W'(tail_pos);
        r.wrap = wrap_st;
        return r;
    endfunction

    function automatic void check_field(string tag, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
            fail_count++;
        end
    endfunction

    // Wait until every expected result has come back, with input idle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write over the configuration port while the buffer is idle.
    task automatic write_reg(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (a[2] == REG_CAPACITY)
        begin
            cap_reg = d[CNT_W-1:0];
            clear_ring();
        end
    endtask

    // Offer one operation and wait for its transfer.
    task automatic push_item(input func_t f, input logic [DATA_W-1:0] d,
                             input logic [CNT_W-1:0] a, input logic typed,
                             input ring_res_t typed_res);
        ring_res_t r;
        if (!calm && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        r = ring_apply(f, d, a);
        pending_status.push_back(typed ? typed_res : r);
        in_valid <= 1'b1;
        func <= f;
        data_in <= d;
        amount <= a;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stimulus: directed rows, then random phases at several capacities.
    initial
    begin
        int cap_v;
        int wr_w;
        int c;
        int pick;
        func_t f;
        logic [CNT_W-1:0] a;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_PLAN; i++)
        begin
            if (PLAN[i].cfg)
                write_reg(PLAN[i].addr, PLAN[i].wdata);
            else
                push_item(PLAN[i].f, PLAN[i].din, PLAN[i].amt, PLAN[i].typed, PLAN[i].res);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: cap_v = 1024;
                1: cap_v = 1;
                2: cap_v = 2;
                3: cap_v = 5;
                4: cap_v = 1023;
                5: cap_v = 0;
                6: cap_v = 2047;
                7: cap_v = $urandom_range(3, 40);
                8: cap_v = $urandom_range(41, 1024);
                9: cap_v = 17;
                default: cap_v = $urandom_range(1, 12);
            endcase
            write_reg(CAP_ADDR, ($urandom & 32'hFFFF_F800) | PDATA_W'(cap_v));
            calm = (ph == 3);
            if (ph == 0)
                hold_request = 1'b1;
            // Each phase leans toward filling or toward draining.
            wr_w = $urandom_range(22, 42);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                c = eff_capacity();
                pick = $urandom_range(0, 99);
                if (pick < wr_w)
                    f = FN_WR_BYTE;
                else if (pick < 60)
                    f = FN_RD_BYTE;
                else if (pick < 68)
                    f = FN_WR_SPAN;
                else if (pick < 76)
                    f = FN_RD_SPAN;
                else if (pick < 82)
                    f = FN_WR_ADV;
                else if (pick < 88)
                    f = FN_RD_ADV;
                else if (pick < 91)
                    f = FN_CLEAR;
                else
                    f = FN_STATUS;

                case ($urandom_range(0, 9))
                    0, 1: a = CNT_W'($urandom_range(0, 2047));
                    2: a = CNT_W'($urandom_range(0, 3));
                    default: a = CNT_W'($urandom_range(0, c + 1));
                endcase

                // Never read a store byte that no write has filled.
                if (f == FN_RD_BYTE && rd_span_avail(c) >= 1 && !byte_seen[head_pos])
                    f = FN_WR_BYTE;
                push_item(f, DATA_W'($urandom_range(0, 255)), a, 1'b0, '0);
            end
            calm = 1'b0;
        end

        wait_drained();
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side: check each transfer, then pick the next stall value.
    always @(posedge clk)
    begin
        ring_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: result with no expectation, granted %0d", $time, granted);
                fail_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("granted", 32'(want.granted), 32'(granted));
                check_field("data_out", 32'(want.data), 32'(data_out));
                check_field("read_remaining", 32'(want.rd_rem), 32'(read_remaining));
                check_field("write_remaining", 32'(want.wr_rem), 32'(write_remaining));
                check_field("read_contiguous", 32'(want.rd_contig), 32'(read_contiguous));
                check_field("write_contiguous", 32'(want.wr_contig),
                            32'(write_contiguous));
                check_field("read_position", 32'(want.rd_pos), 32'(read_position));
                check_field("write_position", 32'(want.wr_pos), 32'(write_position));
                check_field("wrapping", 32'(want.wrap), 32'(wrapping));
            end
        end

        // One long hold-off lets the block fill up and stall its input.
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_request && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 22);
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_status.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule

>>> files.f
rtl/core/wbrb_pkg.sv
rtl/core/wbrb_ram.sv
rtl/core/wbrb_ptr.sv
rtl/core/wrapping_byte_ring_buffer_unit.sv
dv/wrapping_byte_ring_buffer_unit_tb.sv
